// ===== sv/rehe_pkg.sv =====
// shared types and constants for the ring hop enumerator
`default_nettype none
package rehe_pkg;

  localparam int OCC_W = 64;
  localparam int WGT_W = 32;
  localparam int CFG_IDX_W = 2;
  // hop count times rate, at most 32 hops of a 32 bit rate
  localparam int ACC_W = 38;

  localparam logic [WGT_W-1:0] Q_ONE = 32'h8000_0000;

  localparam logic [CFG_IDX_W-1:0] REG_HOP_WEIGHT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOP_RATE = 2'd1;

  localparam logic [WGT_W-1:0] HOP_WEIGHT_RST = 32'd42099227;
  localparam logic [WGT_W-1:0] HOP_RATE_RST = 32'd42949673;

  typedef struct packed {
    logic [OCC_W-1:0] occ;
    logic [OCC_W-1:0] hops;
  } entry_t;

endpackage
`default_nettype wire

// ===== sv/rehe_front.sv =====
// front part: masks the ring word and marks every site that can hop
`default_nettype none
module rehe_front #(
  parameter int SITES = 64
) (
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [rehe_pkg::OCC_W-1:0] occupancy,
  output logic                            push,
  output rehe_pkg::entry_t                push_entry,
  input  wire logic                       full
);

  localparam logic [rehe_pkg::OCC_W-1:0] RING_MASK =
    (SITES >= rehe_pkg::OCC_W) ? {rehe_pkg::OCC_W{1'b1}} :
    ((rehe_pkg::OCC_W)'(1) << SITES) - (rehe_pkg::OCC_W)'(1);

  logic [rehe_pkg::OCC_W-1:0] occ;
  logic [rehe_pkg::OCC_W-1:0] hops;

  assign occ = occupancy & RING_MASK;

  // site k hops when it is full and its successor on the ring is empty
  for (genvar k = 0; k < rehe_pkg::OCC_W; k++) begin : g_site
    if (k < SITES) begin : g_in
      assign hops[k] = occ[k] & ~occ[(k + 1) % SITES];
    end else begin : g_out
      assign hops[k] = 1'b0;
    end
  end

  assign in_stall = full;
  assign push = in_valid & ~full;
  assign push_entry.occ = occ;
  assign push_entry.hops = hops;

endmodule
`default_nettype wire

// ===== sv/rehe_fifo.sv =====
// small register queue between the front and back parts
`default_nettype none
module rehe_fifo #(
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire rehe_pkg::entry_t push_entry,
  output logic                  full,
  input  wire logic             pop,
  output rehe_pkg::entry_t      pop_entry,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rehe_pkg::entry_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  assign full = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign pop_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/rehe_back.sv =====
// back part: emits the hop results lowest site first, then the diagonal when its weight is positive
`default_nettype none
module rehe_back #(
  parameter int SITES = 64
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       empty,
  output logic                            pop,
  input  wire rehe_pkg::entry_t           pop_entry,
  input  wire logic [rehe_pkg::WGT_W-1:0] hop_weight,
  input  wire logic [rehe_pkg::WGT_W-1:0] hop_rate,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [rehe_pkg::OCC_W-1:0]      next_occupancy,
  output logic [rehe_pkg::WGT_W-1:0]      weight,
  output logic                            is_diagonal,
  output logic                            last
);

  localparam int OW = rehe_pkg::OCC_W;
  localparam int AW = rehe_pkg::ACC_W;

  logic          busy;
  logic [OW-1:0] occ;
  logic [OW-1:0] hops;
  logic [AW-1:0] acc;

  logic          adv;
  logic [OW-1:0] low;
  logic [OW-1:0] succ;
  logic [AW-1:0] acc_next;
  logic          only_one;
  logic          diag_ok;

  assign adv = busy & (~out_valid | ~out_stall);
  assign pop = ~busy & ~empty;

  // lowest remaining hop site and the site it moves to
  assign low = hops & (~hops + OW'(1));
  assign succ = (low[SITES-1] ? OW'(1) : '0) | ((low << 1) & ~(OW'(1) << SITES));
  assign acc_next = acc + AW'(hop_rate);
  assign only_one = ((hops & (hops - OW'(1))) == '0);
  assign diag_ok = (acc_next < AW'(rehe_pkg::Q_ONE));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // pop and adv never coincide: pop needs an idle back part, adv a busy one
      if (pop) begin
        busy <= 1'b1;
      end else if (adv && (hops == '0 || (only_one && !diag_ok))) begin
        busy <= 1'b0;
      end
      if (adv) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      occ <= pop_entry.occ;
      hops <= pop_entry.hops;
      acc <= '0;
    end else if (adv) begin
      if (hops != '0) begin
        next_occupancy <= occ ^ (low | succ);
        weight <= hop_weight;
        is_diagonal <= 1'b0;
        last <= only_one & ~diag_ok;
        hops <= hops ^ low;
        acc <= acc_next;
      end else begin
        // only reached when the diagonal is positive, so acc is below one
        next_occupancy <= occ;
        weight <= rehe_pkg::Q_ONE - acc[rehe_pkg::WGT_W-1:0];
        is_diagonal <= 1'b1;
        last <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/ring_exclusion_hop_enumerator_unit.sv =====
// top level of the ring hop enumerator
//
//   channel   direction  handshake               payload
//   cfg       in         cfg_write               cfg_index, cfg_data
//   in        in         in_valid / in_stall     occupancy
//   out       out        out_valid / out_stall   next_occupancy, weight, is_diagonal, last
//
// an item leaves the queue and then gives one result per hop, plus the diagonal when its weight is positive;
// the back part emits one result per cycle while the output is not stalled
// the front takes a new item whenever the two entry queue has room
// reset is synchronous, clears the queue and the back part and loads both registers with their reset values
// a stalled output holds its result while the queue keeps filling
`default_nettype none
module ring_exclusion_hop_enumerator_unit #(
  parameter int SITES = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write,
  input  wire logic [rehe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rehe_pkg::WGT_W-1:0]     cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [rehe_pkg::OCC_W-1:0]     occupancy,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [rehe_pkg::OCC_W-1:0]          next_occupancy,
  output logic [rehe_pkg::WGT_W-1:0]          weight,
  output logic                                is_diagonal,
  output logic                                last
);

  logic [rehe_pkg::WGT_W-1:0] hop_weight;
  logic [rehe_pkg::WGT_W-1:0] hop_rate;

  logic             push;
  rehe_pkg::entry_t push_entry;
  logic             full;
  logic             pop;
  rehe_pkg::entry_t pop_entry;
  logic             empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      hop_weight <= rehe_pkg::HOP_WEIGHT_RST;
      hop_rate <= rehe_pkg::HOP_RATE_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        rehe_pkg::REG_HOP_WEIGHT: hop_weight <= cfg_data;
        rehe_pkg::REG_HOP_RATE: hop_rate <= cfg_data;
        default: ;
      endcase
    end
  end

  rehe_front #(.SITES(SITES)) u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .occupancy  (occupancy),
    .push       (push),
    .push_entry (push_entry),
    .full       (full)
  );

  rehe_fifo #(.DEPTH(2)) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .empty      (empty)
  );

  rehe_back #(.SITES(SITES)) u_back (
    .clk            (clk),
    .rst            (rst),
    .empty          (empty),
    .pop            (pop),
    .pop_entry      (pop_entry),
    .hop_weight     (hop_weight),
    .hop_rate       (hop_rate),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .next_occupancy (next_occupancy),
    .weight         (weight),
    .is_diagonal    (is_diagonal),
    .last           (last)
  );

endmodule
`default_nettype wire

// ===== sv/rehe_checker.sv =====
// port level checks for the ring hop enumerator, bound to the top level
`default_nettype none
module rehe_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       out_valid,
  input wire logic                       out_stall,
  input wire logic [rehe_pkg::OCC_W-1:0] next_occupancy,
  input wire logic [rehe_pkg::WGT_W-1:0] weight,
  input wire logic                       is_diagonal,
  input wire logic                       last
);

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst && $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

  // a stalled transaction stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(next_occupancy) && $stable(weight))
    else $error("stalled output changed");

  // the diagonal always closes the transaction group
  a_diag_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_diagonal |-> last)
    else $error("diagonal without last");

  // diagonal weight is positive and at most one
  a_diag_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_diagonal |-> weight != '0 && weight <= rehe_pkg::Q_ONE)
    else $error("diagonal weight out of range");

endmodule

bind ring_exclusion_hop_enumerator_unit rehe_checker u_rehe_checker (.*);
`default_nettype wire
